@@ hw/rtl/lli_pkg.sv @@
// ----------------------------------------------------------------------------
// lli_pkg: shared constants for the line intersection block
// Field widths of the stream items and the output saturation limits.
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int IN_FIELD_W = 16;
    localparam int IN_FIELDS  = 8;
    localparam int IN_DATA_W  = IN_FIELD_W * IN_FIELDS;
    localparam int OUT_W      = 48;
    localparam int OUT_DATA_W = 104;

    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ hw/rtl/lli_front.sv @@
// ----------------------------------------------------------------------------
// lli_front: determinant and numerator pipeline
// Five register stages: differences and point products, determinant products
// and line constants, numerator products, numerator sums, then magnitudes,
// signs, divider overflow check and the divider's starting remainder.
// ----------------------------------------------------------------------------
module lli_front #(
    parameter int CW  = 16,
    parameter int FB  = 16,
    parameter int DW  = 35,
    parameter int DVW = 67
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [lli_pkg::IN_DATA_W-1:0]          in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [DW-1:0]                          den,
    output logic                                   found,
    output logic [1:0][DW-1:0]                     rem0,
    output logic [1:0][lli_pkg::OUT_W-1:0]         work0,
    output logic [1:0]                             neg,
    output logic [1:0]                             ovf
);

    localparam int FW   = lli_pkg::IN_FIELD_W;
    localparam int OW   = lli_pkg::OUT_W;
    localparam int DETW = 2 * CW + 3;
    localparam int NMW  = 3 * CW + 3;
    localparam int NW   = NMW + FB;
    localparam int HW   = DVW - OW;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic [4:0] v_reg;
    logic [4:0] en;

    assign en[4] = !v_reg[4] || out_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
        end
    end

    // Stage 1: coordinates, differences and point cross products.
    logic signed [CW-1:0] c [8];
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            c[i] = $signed(in_data[i*FW +: CW]);
        end
    end

    logic signed [CW:0]     dax_next, day_next, dbx_next, dby_next;
    logic signed [2*CW-1:0] p03_next, p12_next, p47_next, p56_next;
    logic signed [CW:0]     dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [2*CW-1:0] p03_reg, p12_reg, p47_reg, p56_reg;

    assign dax_next = (CW+1)'(c[0]) - (CW+1)'(c[2]);
    assign day_next = (CW+1)'(c[1]) - (CW+1)'(c[3]);
    assign dbx_next = (CW+1)'(c[4]) - (CW+1)'(c[6]);
    assign dby_next = (CW+1)'(c[5]) - (CW+1)'(c[7]);
    assign p03_next = c[0] * c[3];
    assign p12_next = c[1] * c[2];
    assign p47_next = c[4] * c[7];
    assign p56_next = c[5] * c[6];

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            dax_reg <= dax_next;
            day_reg <= day_next;
            dbx_reg <= dbx_next;
            dby_reg <= dby_next;
            p03_reg <= p03_next;
            p12_reg <= p12_next;
            p47_reg <= p47_next;
            p56_reg <= p56_next;
        end
    end

    // Stage 2: determinant products and the two line constants.
    logic signed [2*CW+1:0] da_next, db_next, da_reg, db_reg;
    logic signed [2*CW:0]   ca_next, cb_next, ca_reg, cb_reg;
    logic signed [CW:0]     dax2_reg, day2_reg, dbx2_reg, dby2_reg;

    assign da_next = dax_reg * dby_reg;
    assign db_next = day_reg * dbx_reg;
    assign ca_next = (2*CW+1)'(p03_reg) - (2*CW+1)'(p12_reg);
    assign cb_next = (2*CW+1)'(p47_reg) - (2*CW+1)'(p56_reg);

    always_ff @(posedge clk)
    begin
        if (en[1] && v_reg[0])
        begin
            da_reg   <= da_next;
            db_reg   <= db_next;
            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            dbx2_reg <= dbx_reg;
            dby2_reg <= dby_reg;
        end
    end

    // Stage 3: determinant and numerator products.
    logic signed [DETW-1:0]  det_next, det3_reg;
    logic signed [3*CW+1:0]  mx1_next, mx2_next, my1_next, my2_next;
    logic signed [3*CW+1:0]  mx1_reg, mx2_reg, my1_reg, my2_reg;

    assign det_next = DETW'(da_reg) - DETW'(db_reg);
    assign mx1_next = dbx2_reg * ca_reg;
    assign mx2_next = dax2_reg * cb_reg;
    assign my1_next = dby2_reg * ca_reg;
    assign my2_next = day2_reg * cb_reg;

    always_ff @(posedge clk)
    begin
        if (en[2] && v_reg[1])
        begin
            det3_reg <= det_next;
            mx1_reg  <= mx1_next;
            mx2_reg  <= mx2_next;
            my1_reg  <= my1_next;
            my2_reg  <= my2_next;
        end
    end

    // Stage 4: numerators.
    logic signed [NMW-1:0]  nx_next, ny_next, nx_reg, ny_reg;
    logic signed [DETW-1:0] det4_reg;

    assign nx_next = NMW'(mx1_reg) - NMW'(mx2_reg);
    assign ny_next = NMW'(my1_reg) - NMW'(my2_reg);

    always_ff @(posedge clk)
    begin
        if (en[3] && v_reg[2])
        begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            det4_reg <= det3_reg;
        end
    end

    // Stage 5: magnitudes and the divider start. The dividend is
    // |num| * 2^FB; its bits above the 48 quotient bits form the starting
    // remainder, and if that already reaches the divisor the quotient
    // cannot fit in 48 bits.
    logic [DW-1:0]   dmag;
    logic [NMW-1:0]  nmag [2];
    logic [DVW-1:0]  dvd  [2];
    logic [DW-1:0]   den_reg;
    logic            found_reg;
    logic [1:0][DW-1:0] rem_reg;
    logic [1:0][OW-1:0] work_reg;
    logic [1:0]      neg_reg, ovf_reg;
    logic [1:0][DW-1:0] rem_next;
    logic [1:0][OW-1:0] work_next;
    logic [1:0]      neg_next, ovf_next;

    assign dmag    = DW'(det4_reg[DETW-1] ? -det4_reg : det4_reg);
    assign nmag[0] = NMW'(nx_reg[NMW-1] ? -nx_reg : nx_reg);
    assign nmag[1] = NMW'(ny_reg[NMW-1] ? -ny_reg : ny_reg);

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            dvd[k]       = DVW'({nmag[k], {FB{1'b0}}});
            work_next[k] = dvd[k][OW-1:0];
            ovf_next[k]  = CMPW'(dvd[k][DVW-1:OW]) >= CMPW'(dmag);
            rem_next[k]  = DW'(dvd[k][DVW-1:OW]);
        end
        neg_next[0] = nx_reg[NMW-1] ^ det4_reg[DETW-1];
        neg_next[1] = ny_reg[NMW-1] ^ det4_reg[DETW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[4] && v_reg[3])
        begin
            den_reg   <= dmag;
            found_reg <= (det4_reg != '0);
            rem_reg   <= rem_next;
            work_reg  <= work_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign den   = den_reg;
    assign found = found_reg;
    assign rem0  = rem_reg;
    assign work0 = work_reg;
    assign neg   = neg_reg;
    assign ovf   = ovf_reg;

endmodule

@@ hw/rtl/lli_div_stage.sv @@
// ----------------------------------------------------------------------------
// lli_div_stage: one restoring division step for both coordinates
// Shifts the next dividend bit into the remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module lli_div_stage #(
    parameter int DW = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    input  logic [DW-1:0]                      den_in,
    input  logic                               found_in,
    input  logic [1:0][DW-1:0]                 rem_in,
    input  logic [1:0][lli_pkg::OUT_W-1:0]     work_in,
    input  logic [1:0]                         neg_in,
    input  logic [1:0]                         ovf_in,
    output logic [DW-1:0]                      den_out,
    output logic                               found_out,
    output logic [1:0][DW-1:0]                 rem_out,
    output logic [1:0][lli_pkg::OUT_W-1:0]     work_out,
    output logic [1:0]                         neg_out,
    output logic [1:0]                         ovf_out
);

    localparam int OW = lli_pkg::OUT_W;

    logic                v_reg;
    logic [DW-1:0]       den_reg;
    logic                found_reg;
    logic [1:0][DW-1:0]  rem_reg, rem_next;
    logic [1:0][OW-1:0]  work_reg, work_next;
    logic [1:0]          neg_reg, ovf_reg;
    logic [DW:0]         trial [2];
    logic [DW:0]         diff  [2];
    logic [1:0]          fits;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            trial[k]     = {rem_in[k], work_in[k][OW-1]};
            diff[k]      = trial[k] - {1'b0, den_in};
            fits[k]      = trial[k] >= {1'b0, den_in};
            rem_next[k]  = fits[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
            work_next[k] = {work_in[k][OW-2:0], fits[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            den_reg   <= den_in;
            found_reg <= found_in;
            rem_reg   <= rem_next;
            work_reg  <= work_next;
            neg_reg   <= neg_in;
            ovf_reg   <= ovf_in;
        end
    end

    assign den_out   = den_reg;
    assign found_out = found_reg;
    assign rem_out   = rem_reg;
    assign work_out  = work_reg;
    assign neg_out   = neg_reg;
    assign ovf_out   = ovf_reg;

endmodule

@@ hw/rtl/line_line_intersection.sv @@
// ----------------------------------------------------------------------------
// line_line_intersection: crossing point of two lines given by two points
// Cramer's rule with a pipelined restoring divider and saturating
// fixed-point output.
//
//  channel  dir  handshake           payload
//  s_axis   in   s_tvalid/s_tready   s_tdata: eight 16-bit signed coordinates
//  m_axis   out  m_tvalid/m_tready   m_tdata: found, cross_x, cross_y, clipped
//
// One request is taken per cycle while the output is not stalled. The path
// holds 54 register stages (five arithmetic stages, one divider stage per
// quotient bit, output register).
// Each stage holds its own valid bit and stalls only when full and blocked,
// so bubbles are squeezed out and a stalled output loses nothing.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module line_line_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y (16 bits each, from bit 0 up)
    input  logic [lli_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found [0], cross_x [48:1], cross_y [96:49], clipped [97], zeros above
    output logic [lli_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CW   = (COORD_BITS < lli_pkg::IN_FIELD_W) ? COORD_BITS
                                                             : lli_pkg::IN_FIELD_W;
    localparam int OW   = lli_pkg::OUT_W;
    localparam int DW   = 2 * CW + 3;
    localparam int NW   = 3 * CW + 3 + FRAC_BITS;
    localparam int DVW  = (NW > OW + 1) ? NW : OW + 1;
    localparam int NSTG = OW;

    logic [NSTG:0]               sv;
    logic [NSTG:0]               sr;
    logic [NSTG:0][DW-1:0]       den_s;
    logic [NSTG:0]               found_s;
    logic [NSTG:0][1:0][DW-1:0]  rem_s;
    logic [NSTG:0][1:0][OW-1:0]  work_s;
    logic [NSTG:0][1:0]          neg_s;
    logic [NSTG:0][1:0]          ovf_s;

    lli_front #(
        .CW  (CW),
        .FB  (FRAC_BITS),
        .DW  (DW),
        .DVW (DVW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (sv[0]),
        .out_ready (sr[0]),
        .den       (den_s[0]),
        .found     (found_s[0]),
        .rem0      (rem_s[0]),
        .work0     (work_s[0]),
        .neg       (neg_s[0]),
        .ovf       (ovf_s[0])
    );

    for (genvar i = 0; i < NSTG; i++)
    begin : g_div
        lli_div_stage #(
            .DW (DW)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv[i]),
            .in_ready  (sr[i]),
            .out_valid (sv[i+1]),
            .out_ready (sr[i+1]),
            .den_in    (den_s[i]),
            .found_in  (found_s[i]),
            .rem_in    (rem_s[i]),
            .work_in   (work_s[i]),
            .neg_in    (neg_s[i]),
            .ovf_in    (ovf_s[i]),
            .den_out   (den_s[i+1]),
            .found_out (found_s[i+1]),
            .rem_out   (rem_s[i+1]),
            .work_out  (work_s[i+1]),
            .neg_out   (neg_s[i+1]),
            .ovf_out   (ovf_s[i+1])
        );
    end

    // Output stage: apply sign and saturate each quotient to 48 bits.
    logic               out_v_reg;
    logic [OW-1:0]      q    [2];
    logic [OW-1:0]      coord[2];
    logic [1:0]         sat;
    logic               fnd;
    logic [lli_pkg::OUT_DATA_W-1:0] data_reg, data_next;

    assign sr[NSTG] = !out_v_reg || m_tready;
    assign fnd      = found_s[NSTG];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            q[k] = work_s[NSTG][k];
            if (neg_s[NSTG][k])
            begin
                sat[k]   = ovf_s[NSTG][k] || (q[k][OW-1] && (q[k][OW-2:0] != '0));
                coord[k] = sat[k] ? lli_pkg::NEG_MIN : -q[k];
            end
            else
            begin
                sat[k]   = ovf_s[NSTG][k] || q[k][OW-1];
                coord[k] = sat[k] ? lli_pkg::POS_MAX : q[k];
            end
        end
        data_next = '0;
        if (fnd)
        begin
            data_next[0]           = 1'b1;
            data_next[OW:1]        = coord[0];
            data_next[2*OW:OW+1]   = coord[1];
            data_next[2*OW+1]      = sat[0] || sat[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (sr[NSTG])
        begin
            out_v_reg <= sv[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sr[NSTG] && sv[NSTG])
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = data_reg;

    // A missing crossing carries no coordinates and no clip flag.
    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2*OW+1:1] == '0))
        else $error("parallel result carries nonzero payload");

    // A clipped result has a coordinate pinned at a saturation limit.
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2*OW+1]) |->
        (m_tdata[OW:1] == lli_pkg::POS_MAX || m_tdata[OW:1] == lli_pkg::NEG_MIN ||
         m_tdata[2*OW:OW+1] == lli_pkg::POS_MAX ||
         m_tdata[2*OW:OW+1] == lli_pkg::NEG_MIN))
        else $error("clip flag without saturated coordinate");

    // With the output register empty every stage can advance.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // Padding bits above the clip flag stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[lli_pkg::OUT_DATA_W-1:2*OW+2] == '0))
        else $error("padding bits set");

endmodule
